// File: src/mpsm_pkg.sv
`default_nettype none
package mpsm_pkg;

    // Default sizes of the automaton.
    localparam int DEF_MAX_NODES = 512;
    localparam int DEF_ALPHABET  = 256;

    // Operation codes.
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_END     = 3'd2;
    localparam logic [2:0] OP_BUILD   = 3'd3;
    localparam logic [2:0] OP_SCAN    = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_PHASE = 2'd2;

    // Command beat.
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] symbol;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic       matched;
        logic [8:0] automaton_state;
        logic [1:0] status;
    } t_out;

endpackage
`default_nettype wire

// File: src/mpsm_ram.sv
`default_nettype none
module mpsm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/multi_pattern_string_matcher_top.sv
// Channel  | Ports                       | Handshake
// ---------+-----------------------------+------------------------------------
// command  | i_start, busy, i_in         | beat taken when i_start && !busy
// result   | o_valid, o_res              | beat shown one cycle, no backpressure
//
// Clear sweeps all MAX_NODES*ALPHABET goto entries (131072 at default sizes),
// zeroing failure links and accept flags on the way; reset runs the same sweep
// and busy stays high during it. Insert reads the goto table, then follows or
// allocates an edge; scan reads the goto table, then the accept flag; end,
// restart and rejected beats are answered straight from idle. Build reads every
// root edge, then each node's edges, paced by the single read port of the goto
// table. The result strobe is registered; the receiver cannot stall it.
`default_nettype none
module multi_pattern_string_matcher_top #(
    parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES,
    parameter int ALPHABET  = mpsm_pkg::DEF_ALPHABET
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                busy,
    input  wire mpsm_pkg::t_in  i_in,
    output logic                o_valid,
    output mpsm_pkg::t_out      o_res
);

    import mpsm_pkg::*;

    localparam int NW      = $clog2(MAX_NODES);
    localparam int CW      = NW + 1;
    localparam int SW      = $clog2(ALPHABET);
    localparam int G_DEPTH = MAX_NODES * ALPHABET;
    localparam int GW      = $clog2(G_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_INS_RD, S_SCAN_RD, S_SCAN_ACC,
        S_A_RD, S_A_CHK, S_B_POP, S_B_FAIL, S_B_FO,
        S_E_RU, S_E_RT, S_E_ACT, S_E_AT, S_E_AU
    } t_state;

    t_state        r_state, n_state;
    logic [GW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_c, n_c;
    logic [SW-1:0] r_sym, n_sym;
    logic [CW-1:0] r_node_count, n_node_count;
    logic [NW-1:0] r_cursor, n_cursor;
    logic [NW-1:0] r_pos, n_pos;
    logic          r_built, n_built;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_tail, n_tail;
    logic [NW-1:0] r_o, n_o;
    logic [NW-1:0] r_fo, n_fo;
    logic [NW-1:0] r_u, n_u;
    logic          r_tacc, n_tacc;
    logic          r_clr_report, n_clr_report;
    logic          n_valid;
    t_out          n_res;

    logic [SW-1:0] w_sym;

    logic          g_we;
    logic [GW-1:0] g_waddr, g_raddr;
    logic [NW-1:0] g_wdata, g_rdata;
    logic          f_we;
    logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic          a_we;
    logic [NW-1:0] a_waddr, a_raddr;
    logic          a_wdata, a_rdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    // Flat goto-table address of one node's edge.
    function automatic logic [GW-1:0] g_addr(input logic [NW-1:0] node,
                                             input logic [SW-1:0] sym);
        return GW'(node) * GW'(ALPHABET) + GW'(sym);
    endfunction

    // Result beat with the node shown on 9 bits.
    function automatic t_out mk_res(input logic m, input logic [NW-1:0] node,
                                    input logic [1:0] st);
        logic [NW+8:0] wide;
        t_out          res;
        wide                = {9'd0, node};
        res.matched         = m;
        res.automaton_state = wide[8:0];
        res.status          = st;
        return res;
    endfunction

    assign w_sym = SW'(i_in.symbol % ALPHABET);
    assign busy  = (r_state != S_IDLE);

    // Next-state logic and memory port control.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_c          = r_c;
        n_sym        = r_sym;
        n_node_count = r_node_count;
        n_cursor     = r_cursor;
        n_pos        = r_pos;
        n_built      = r_built;
        n_head       = r_head;
        n_tail       = r_tail;
        n_o          = r_o;
        n_fo         = r_fo;
        n_u          = r_u;
        n_tacc       = r_tacc;
        n_clr_report = r_clr_report;
        n_valid      = 1'b0;
        n_res        = o_res;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        a_we = 1'b0; a_waddr = '0; a_wdata = 1'b0; a_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_in.operation)
                        OP_CLEAR: begin
                            n_cnt        = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLEAR;
                        end
                        OP_INSERT: begin
                            if (r_built) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(1'b0, r_cursor, ST_PHASE);
                            end else begin
                                g_raddr = g_addr(r_cursor, w_sym);
                                n_sym   = w_sym;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_END: begin
                            n_valid = 1'b1;
                            if (r_built) begin
                                n_res = mk_res(1'b0, r_cursor, ST_PHASE);
                            end else begin
                                a_we     = 1'b1;
                                a_waddr  = r_cursor;
                                a_wdata  = 1'b1;
                                n_cursor = '0;
                                n_res    = mk_res(1'b0, '0, ST_OK);
                            end
                        end
                        OP_BUILD: begin
                            if (r_built) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(1'b0, '0, ST_PHASE);
                            end else begin
                                n_c     = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_state = S_A_RD;
                            end
                        end
                        OP_SCAN: begin
                            if (!r_built) begin
                                n_valid = 1'b1;
                                n_res   = mk_res(1'b0, r_pos, ST_PHASE);
                            end else begin
                                g_raddr = g_addr(r_pos, w_sym);
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_RESTART: begin
                            n_pos   = '0;
                            n_valid = 1'b1;
                            n_res   = mk_res(1'b0, '0, ST_OK);
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_res   = mk_res(1'b0, '0, ST_PHASE);
                        end
                    endcase
                end
            end

            // Zero one goto entry per cycle, and the node tables on the way.
            S_CLEAR: begin
                g_we    = 1'b1;
                g_waddr = r_cnt;
                if (r_cnt < GW'(MAX_NODES)) begin
                    f_we    = 1'b1;
                    f_waddr = r_cnt[NW-1:0];
                    a_we    = 1'b1;
                    a_waddr = r_cnt[NW-1:0];
                end
                if (r_cnt == GW'(G_DEPTH - 1)) begin
                    n_node_count = '0;
                    n_cursor     = '0;
                    n_pos        = '0;
                    n_built      = 1'b0;
                    n_clr_report = 1'b0;
                    n_valid      = r_clr_report;
                    n_res        = mk_res(1'b0, '0, ST_OK);
                    n_state      = S_IDLE;
                end else begin
                    n_cnt = r_cnt + GW'(1);
                end
            end

            // Follow an existing edge or allocate a new node.
            S_INS_RD: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (g_rdata != '0) begin
                    n_cursor = g_rdata;
                    n_res    = mk_res(1'b0, g_rdata, ST_OK);
                end else if (CW'(r_node_count + CW'(1)) >= CW'(MAX_NODES)) begin
                    n_res = mk_res(1'b0, r_cursor, ST_FULL);
                end else begin
                    g_we         = 1'b1;
                    g_waddr      = g_addr(r_cursor, r_sym);
                    g_wdata      = r_node_count[NW-1:0] + NW'(1);
                    n_node_count = r_node_count + CW'(1);
                    n_cursor     = r_node_count[NW-1:0] + NW'(1);
                    n_res        = mk_res(1'b0, r_node_count[NW-1:0] + NW'(1), ST_OK);
                end
            end

            // Scan: new state from the goto table, then its accept flag.
            S_SCAN_RD: begin
                n_pos   = g_rdata;
                a_raddr = g_rdata;
                n_state = S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
                n_valid = 1'b1;
                n_res   = mk_res(a_rdata, r_pos, ST_OK);
                n_state = S_IDLE;
            end

            // Build: enqueue the children of the root.
            S_A_RD: begin
                g_raddr = g_addr('0, r_c);
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (g_rdata != '0 && r_tail < CW'(MAX_NODES)) begin
                    f_we    = 1'b1;
                    f_waddr = g_rdata;
                    q_we    = 1'b1;
                    q_waddr = r_tail[NW-1:0];
                    q_wdata = g_rdata;
                    n_tail  = r_tail + CW'(1);
                end
                if (r_c == SW'(ALPHABET - 1)) begin
                    n_state = S_B_POP;
                end else begin
                    n_c     = r_c + SW'(1);
                    n_state = S_A_RD;
                end
            end

            // Build: take the next node off the queue, or finish.
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_built  = 1'b1;
                    n_cursor = '0;
                    n_pos    = '0;
                    n_valid  = 1'b1;
                    n_res    = mk_res(1'b0, '0, ST_OK);
                    n_state  = S_IDLE;
                end else begin
                    q_raddr = r_head[NW-1:0];
                    n_head  = r_head + CW'(1);
                    n_state = S_B_FAIL;
                end
            end
            S_B_FAIL: begin
                n_o     = q_rdata;
                f_raddr = q_rdata;
                n_state = S_B_FO;
            end
            S_B_FO: begin
                n_fo    = f_rdata;
                n_c     = '0;
                n_state = S_E_RU;
            end

            // Build: per symbol, read own edge and the failure node's edge.
            S_E_RU: begin
                g_raddr = g_addr(r_o, r_c);
                n_state = S_E_RT;
            end
            S_E_RT: begin
                n_u     = g_rdata;
                g_raddr = g_addr(r_fo, r_c);
                n_state = S_E_ACT;
            end
            S_E_ACT: begin
                if (r_u == '0) begin
                    g_we    = 1'b1;
                    g_waddr = g_addr(r_o, r_c);
                    g_wdata = g_rdata;
                    if (r_c == SW'(ALPHABET - 1)) begin
                        n_state = S_B_POP;
                    end else begin
                        n_c     = r_c + SW'(1);
                        n_state = S_E_RU;
                    end
                end else begin
                    f_we    = 1'b1;
                    f_waddr = r_u;
                    f_wdata = g_rdata;
                    a_raddr = g_rdata;
                    n_state = S_E_AT;
                end
            end
            S_E_AT: begin
                n_tacc  = a_rdata;
                a_raddr = r_u;
                n_state = S_E_AU;
            end
            S_E_AU: begin
                a_we    = 1'b1;
                a_waddr = r_u;
                a_wdata = a_rdata | r_tacc;
                if (r_tail < CW'(MAX_NODES)) begin
                    q_we    = 1'b1;
                    q_waddr = r_tail[NW-1:0];
                    q_wdata = r_u;
                    n_tail  = r_tail + CW'(1);
                end
                if (r_c == SW'(ALPHABET - 1)) begin
                    n_state = S_B_POP;
                end else begin
                    n_c     = r_c + SW'(1);
                    n_state = S_E_RU;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts a silent clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_clr_report <= 1'b0;
            r_node_count <= '0;
            r_cursor     <= '0;
            r_pos        <= '0;
            r_built      <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            o_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_clr_report <= n_clr_report;
            r_node_count <= n_node_count;
            r_cursor     <= n_cursor;
            r_pos        <= n_pos;
            r_built      <= n_built;
            r_head       <= n_head;
            r_tail       <= n_tail;
            o_valid      <= n_valid;
        end
        r_c    <= n_c;
        r_sym  <= n_sym;
        r_o    <= n_o;
        r_fo   <= n_fo;
        r_u    <= n_u;
        r_tacc <= n_tacc;
        o_res  <= n_res;
    end

    // Goto table, one entry per node and symbol.
    mpsm_ram #(.WIDTH(NW), .DEPTH(G_DEPTH)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    // Failure links.
    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    // Accept flags.
    mpsm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_accept (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    // Breadth-first queue used during build.
    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

endmodule
`default_nettype wire

// File: test/multi_pattern_string_matcher_checker.sv
`default_nettype none
module multi_pattern_string_matcher_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_busy,
    input  wire mpsm_pkg::t_in  i_in,
    input  wire logic           i_valid,
    input  wire mpsm_pkg::t_out i_res,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = mpsm_pkg::DEF_MAX_NODES;
    localparam int SYMS  = mpsm_pkg::DEF_ALPHABET;

    // Shadow copy of the automaton.
    logic [8:0] edge_tbl [0:NODES*SYMS-1];
    logic [8:0] fail_tbl [0:NODES-1];
    logic       accepting [0:NODES-1];
    int         used_nodes;
    int         trie_cursor;
    int         text_state;
    bit         is_built;

    mpsm_pkg::t_out result_fifo [$];

    // Returns the whole shadow automaton to its cleared state.
    function automatic void wipe_automaton();
        for (int i = 0; i < NODES*SYMS; i++) edge_tbl[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            fail_tbl[i] = '0;
            accepting[i] = 1'b0;
        end
        used_nodes = 0;
        trie_cursor = 0;
        text_state = 0;
        is_built = 1'b0;
    endfunction

    // Breadth-first pass: failure links, completed edges, inherited accept flags.
    function automatic void complete_automaton();
        int order [NODES];
        int head;
        int tail;
        int o;
        int fo;
        int u;
        int t;
        head = 0;
        tail = 0;
        for (int c = 0; c < SYMS; c++) begin
            u = edge_tbl[c];
            if (u != 0 && tail < NODES) begin
                fail_tbl[u] = '0;
                order[tail++] = u;
            end
        end
        while (head < tail) begin
            o = order[head++];
            fo = fail_tbl[o];
            for (int c = 0; c < SYMS; c++) begin
                u = edge_tbl[o*SYMS + c];
                t = edge_tbl[fo*SYMS + c];
                if (u == 0) begin
                    edge_tbl[o*SYMS + c] = t[8:0];
                end else begin
                    fail_tbl[u] = t[8:0];
                    accepting[u] = accepting[u] | accepting[t];
                    if (tail < NODES) order[tail++] = u;
                end
            end
        end
    endfunction

    // Expected result of one command beat; updates the shadow state.
    function automatic mpsm_pkg::t_out predict_match(mpsm_pkg::t_in cmd);
        mpsm_pkg::t_out r;
        int nxt;
        int sym;
        r = '0;
        r.status = mpsm_pkg::ST_OK;
        sym = cmd.symbol;
        case (cmd.operation)
            mpsm_pkg::OP_CLEAR: begin
                wipe_automaton();
            end
            mpsm_pkg::OP_INSERT: begin
                if (is_built) begin
                    r.status = mpsm_pkg::ST_PHASE;
                end else begin
                    nxt = edge_tbl[trie_cursor*SYMS + sym];
                    if (nxt != 0) begin
                        trie_cursor = nxt;
                    end else if (used_nodes + 1 >= NODES) begin
                        r.status = mpsm_pkg::ST_FULL;
                    end else begin
                        used_nodes++;
                        edge_tbl[trie_cursor*SYMS + sym] = used_nodes[8:0];
                        trie_cursor = used_nodes;
                    end
                end
                r.automaton_state = trie_cursor[8:0];
            end
            mpsm_pkg::OP_END: begin
                if (is_built) begin
                    r.status = mpsm_pkg::ST_PHASE;
                end else begin
                    accepting[trie_cursor] = 1'b1;
                    trie_cursor = 0;
                end
                r.automaton_state = trie_cursor[8:0];
            end
            mpsm_pkg::OP_BUILD: begin
                if (is_built) begin
                    r.status = mpsm_pkg::ST_PHASE;
                end else begin
                    complete_automaton();
                    is_built = 1'b1;
                    trie_cursor = 0;
                    text_state = 0;
                end
            end
            mpsm_pkg::OP_SCAN: begin
                if (!is_built) begin
                    r.status = mpsm_pkg::ST_PHASE;
                end else begin
                    text_state = edge_tbl[text_state*SYMS + sym];
                    r.matched = accepting[text_state];
                end
                r.automaton_state = text_state[8:0];
            end
            mpsm_pkg::OP_RESTART: begin
                text_state = 0;
            end
            default: begin
                r.status = mpsm_pkg::ST_PHASE;
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        wipe_automaton();
    end

    // Results are checked before the command of the same edge is predicted.
    always @(posedge i_clk) begin
        mpsm_pkg::t_out want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (result_fifo.size() == 0) begin
                    report("unexpected result beat", i_res, 0);
                end else begin
                    want = result_fifo.pop_front();
                    if (i_res.matched !== want.matched)
                        report("matched", i_res.matched, want.matched);
                    if (i_res.automaton_state !== want.automaton_state)
                        report("automaton_state", i_res.automaton_state,
                               want.automaton_state);
                    if (i_res.status !== want.status)
                        report("status", i_res.status, want.status);
                end
            end
            if (i_start && !i_busy) result_fifo.push_back(predict_match(i_in));
        end
        o_pending <= result_fifo.size();
    end
endmodule
`default_nettype wire

// File: test/multi_pattern_string_matcher_top_test.sv
`default_nettype none
module multi_pattern_string_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsm_pkg::*;

    localparam int STALL_LIMIT = 700000;
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_in = '0;
    logic busy;
    logic o_valid;
    t_out o_res;
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    bit   quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    multi_pattern_string_matcher_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .busy   (busy),
        .i_in   (i_in),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    multi_pattern_string_matcher_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_valid     (o_valid),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: too long without any beat in either direction ends the run.
    always @(posedge i_clk) begin
        if ((i_start && !busy) || o_valid || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one command beat and returns after the edge that takes it, sometimes after a random pause.
    task automatic send(logic [2:0] op, logic [7:0] sym);
        i_start <= 1'b1;
        i_in <= '{operation: op, symbol: sym};
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Holds the sender until every outstanding result has come back.
    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Mostly symbols near a base so patterns share prefixes and text matches.
    function automatic logic [7:0] near_sym(logic [7:0] base);
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return base ^ 8'($urandom_range(0, 3));
    endfunction

    // One random phase: patterns, build, then a long text scan with noise.
    task automatic random_phase(int n_pat, int n_scan, int quiet_from);
        logic [7:0] base;
        int len;
        int pick;
        base = 8'($urandom_range(0, 255));
        for (int p = 0; p < n_pat; p++) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) send(OP_INSERT, near_sym(base));
            send(OP_END, 8'($urandom));
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: send(OP_RESTART, 8'($urandom));
                    1: send(OP_SCAN, near_sym(base));
                    2: send(OP_UNDEF_LO, 8'($urandom));
                    default: send(OP_UNDEF_HI, 8'($urandom));
                endcase
            end
        end
        drain();
        send(OP_BUILD, 8'($urandom));
        for (int k = 0; k < n_scan; k++) begin
            if (k == quiet_from) quiet = 1'b1;
            pick = $urandom_range(0, 39);
            case (pick)
                0: send(OP_RESTART, 8'($urandom));
                1: send(OP_INSERT, 8'($urandom));
                2: send(OP_END, 8'($urandom));
                3: send(OP_BUILD, 8'($urandom));
                4: send(OP_UNDEF_LO, 8'($urandom));
                5: send(OP_UNDEF_HI, 8'($urandom));
                default: send(OP_SCAN, near_sym(base));
            endcase
        end
    endtask

    initial begin
        logic [7:0] first_sym;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Node store runs full on one long chain; existing edges still work.
        first_sym = 8'($urandom);
        send(OP_INSERT, first_sym);
        for (int k = 1; k < 511; k++) send(OP_INSERT, 8'($urandom));
        repeat (3) send(OP_INSERT, 8'($urandom));
        send(OP_END, 8'($urandom));
        send(OP_INSERT, first_sym);
        send(OP_END, 8'($urandom));
        send(OP_CLEAR, 8'($urandom));

        // Directed phase: wrong-phase commands, extreme symbols, shared prefixes.
        send(OP_SCAN, 8'h00);
        send(OP_UNDEF_LO, 8'hFF);
        send(OP_UNDEF_HI, 8'h00);
        send(OP_RESTART, 8'h00);
        send(OP_INSERT, 8'h00);
        send(OP_INSERT, 8'hFF);
        send(OP_END, 8'h00);
        send(OP_INSERT, 8'h00);
        send(OP_INSERT, 8'h5A);
        send(OP_END, 8'h00);
        send(OP_INSERT, 8'hFF);
        send(OP_END, 8'h00);
        send(OP_INSERT, 8'hA5);
        send(OP_INSERT, 8'h00);
        send(OP_END, 8'h00);
        drain();
        send(OP_BUILD, 8'h00);
        send(OP_BUILD, 8'hFF);
        send(OP_INSERT, 8'h01);
        send(OP_END, 8'h00);
        send(OP_SCAN, 8'h00);
        send(OP_SCAN, 8'hFF);
        send(OP_SCAN, 8'h5A);
        send(OP_SCAN, 8'hFF);
        send(OP_SCAN, 8'hA5);
        send(OP_SCAN, 8'h00);
        send(OP_RESTART, 8'hFF);
        send(OP_SCAN, 8'h07);
        send(OP_CLEAR, 8'h00);

        // An empty pattern makes the root accepting; build passes the flag to none of the root's children.
        send(OP_END, 8'h00);
        send(OP_INSERT, 8'h03);
        send(OP_INSERT, 8'h04);
        send(OP_END, 8'h00);
        send(OP_BUILD, 8'h00);
        send(OP_SCAN, 8'h03);
        send(OP_SCAN, 8'h04);
        send(OP_SCAN, 8'h09);
        send(OP_CLEAR, 8'h00);

        random_phase(12, 230, -1);
        send(OP_CLEAR, 8'($urandom));
        random_phase(10, 230, -1);
        send(OP_CLEAR, 8'($urandom));
        random_phase(12, 260, 130);

        // Let the last results arrive, then give the verdict.
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
